[hdl/plrtb_pkg.sv]
`default_nettype none
package plrtb_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int CHANNEL_BITS = 16;
   localparam int IDX_W = 8;
   localparam int LEN_W = IDX_W + 1;
   localparam int CNT_W = $clog2(CHANNEL_BITS + 1);
   localparam int LANES = 3;

   localparam logic [1:0] CMD_COLOR = 2'd0;
   localparam logic [1:0] CMD_OPACITY = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic first_point;
      logic [IDX_W-1:0] point_index;
      logic [CHANNEL_BITS-1:0] red_in;
      logic [CHANNEL_BITS-1:0] green_in;
      logic [CHANNEL_BITS-1:0] blue_in;
      logic [CHANNEL_BITS-1:0] opacity_in;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red_out;
      logic [CHANNEL_BITS-1:0] green_out;
      logic [CHANNEL_BITS-1:0] blue_out;
      logic [CHANNEL_BITS-1:0] alpha_out;
      logic in_table;
   } rsp_type;

   typedef struct packed {
      logic cap;
      logic clear;
      logic record;
      logic grow;
      logic div_start;
      logic fill_init;
      logic fill_step;
      logic rd;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic chain_start;
      logic descending;
      logic same_index;
      logic div_done;
      logic fill_last;
   } ctrl_status_type;

endpackage
`default_nettype wire

[hdl/plrtb_lane.sv]
`default_nettype none
module plrtb_lane (
   input wire logic clock,
   input wire logic reset,
   input wire plrtb_pkg::ctrl_cmd_type cmd,
   input wire logic [plrtb_pkg::CHANNEL_BITS-1:0] v0,
   input wire logic [plrtb_pkg::CHANNEL_BITS-1:0] v1,
   input wire logic [plrtb_pkg::IDX_W-1:0] span,
   output logic [plrtb_pkg::CHANNEL_BITS-1:0] value,
   output logic done
);
   import plrtb_pkg::*;

   // The slope (v1 - v0) / span is split once into a floored quotient and a
   // remainder; each entry then adds both and carries the remainder over.
   logic neg_ff;
   logic [CHANNEL_BITS-1:0] shreg_ff, shreg_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff;
   logic signed [CHANNEL_BITS+1:0] q_ff, q_in;
   logic [IDX_W-1:0] r_ff, r_in;
   logic signed [CHANNEL_BITS:0] qd_ff, qd_in;
   logic [IDX_W-1:0] rd_ff, rd_in;

   logic [IDX_W:0] trial;
   logic ge;
   logic signed [CHANNEL_BITS:0] qpos;
   logic signed [CHANNEL_BITS+1:0] qsum;
   logic [IDX_W:0] rsum;
   logic [IDX_W:0] rdiff;

   always_comb begin
      trial = {rem_ff, shreg_ff[CHANNEL_BITS-1]};
      ge = trial >= {1'b0, span};
      rdiff = trial - {1'b0, span};
      rem_in = ge ? rdiff[IDX_W-1:0] : trial[IDX_W-1:0];
      shreg_in = {shreg_ff[CHANNEL_BITS-2:0], ge};

      qpos = signed'({1'b0, shreg_ff});
      if (!neg_ff) begin
         qd_in = qpos;
         rd_in = rem_ff;
      end else if (rem_ff == '0) begin
         qd_in = -qpos;
         rd_in = '0;
      end else begin
         qd_in = -qpos - (CHANNEL_BITS+1)'(1);
         rd_in = span - rem_ff;
      end

      qsum = q_ff + (CHANNEL_BITS+2)'(qd_ff);
      rsum = {1'b0, r_ff} + {1'b0, rd_ff};
      if (rsum >= {1'b0, span}) begin
         rdiff = rsum - {1'b0, span};
         r_in = rdiff[IDX_W-1:0];
         q_in = qsum + (CHANNEL_BITS+2)'(1);
      end else begin
         r_in = rsum[IDX_W-1:0];
         q_in = qsum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start) begin
         cnt_ff <= CNT_W'(CHANNEL_BITS);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= v1 < v0;
         shreg_ff <= (v1 >= v0) ? (v1 - v0) : (v0 - v1);
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         shreg_ff <= shreg_in;
         rem_ff <= rem_in;
      end
      if (cmd.fill_init) begin
         qd_ff <= qd_in;
         rd_ff <= rd_in;
         q_ff <= signed'({2'b00, v0});
         r_ff <= span >> 1;
      end else if (cmd.fill_step) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign value = q_ff[CHANNEL_BITS-1:0];
   assign done = cnt_ff == '0;

endmodule
`default_nettype wire

[hdl/plrtb_datapath.sv]
`default_nettype none
module plrtb_datapath (
   input wire logic clock,
   input wire logic reset,
   input wire plrtb_pkg::req_type req_data,
   input wire plrtb_pkg::ctrl_cmd_type cmd,
   output plrtb_pkg::ctrl_status_type status,
   output plrtb_pkg::rsp_type rsp_data
);
   import plrtb_pkg::*;

   req_type req_ff;
   logic [LEN_W-1:0] length_ff;
   logic [IDX_W-1:0] color_idx_ff;
   logic [CHANNEL_BITS-1:0] color_val_ff [LANES];
   logic color_open_ff;
   logic [IDX_W-1:0] op_idx_ff;
   logic [CHANNEL_BITS-1:0] op_val_ff;
   logic op_open_ff;
   logic [IDX_W-1:0] addr_ff;

   // An entry becomes valid once a color fill, or an alpha fill within the table length, writes it.
   logic [LANES*CHANNEL_BITS-1:0] rgb_mem [TABLE_ENTRIES];
   logic [CHANNEL_BITS-1:0] alpha_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] ent_vld_ff;

   logic [LANES*CHANNEL_BITS-1:0] rd_rgb_ff;
   logic [CHANNEL_BITS-1:0] rd_alpha_ff;
   logic rd_vld_ff, rd_in_table_ff;

   logic is_color, is_opacity;
   logic [IDX_W-1:0] last_idx;
   logic [IDX_W-1:0] span;
   logic [CHANNEL_BITS-1:0] req_rgb [LANES];
   logic [CHANNEL_BITS-1:0] lane_v0 [LANES];
   logic [CHANNEL_BITS-1:0] lane_v1 [LANES];
   logic [CHANNEL_BITS-1:0] lane_val [LANES];
   logic [LANES-1:0] lane_done;
   logic in_len;

   always_comb begin
      is_color = req_ff.cmd == CMD_COLOR;
      is_opacity = req_ff.cmd == CMD_OPACITY;
      last_idx = is_opacity ? op_idx_ff : color_idx_ff;
      span = req_ff.point_index - last_idx;
      req_rgb[0] = req_ff.red_in;
      req_rgb[1] = req_ff.green_in;
      req_rgb[2] = req_ff.blue_in;
      for (int c = 0; c < LANES; c++) begin
         lane_v0[c] = color_val_ff[c];
         lane_v1[c] = req_rgb[c];
      end
      if (is_opacity) begin
         lane_v0[0] = op_val_ff;
         lane_v1[0] = req_ff.opacity_in;
      end
      in_len = {1'b0, addr_ff} < length_ff;

      status.cmd = req_ff.cmd;
      status.chain_start = is_opacity ? (req_ff.first_point || !op_open_ff)
                                      : (req_ff.first_point || !color_open_ff);
      status.descending = req_ff.point_index < last_idx;
      status.same_index = req_ff.point_index == last_idx;
      status.div_done = &lane_done;
      status.fill_last = addr_ff == req_ff.point_index;
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      plrtb_lane u_lane (
         .clock(clock),
         .reset(reset),
         .cmd(cmd),
         .v0(lane_v0[g]),
         .v1(lane_v1[g]),
         .span(span),
         .value(lane_val[g]),
         .done(lane_done[g])
      );
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         req_ff <= req_data;
      end
      if (cmd.fill_init) begin
         addr_ff <= last_idx;
      end else if (cmd.fill_step) begin
         addr_ff <= addr_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         color_idx_ff <= '0;
         color_open_ff <= 1'b0;
         op_idx_ff <= '0;
         op_val_ff <= '0;
         op_open_ff <= 1'b0;
         for (int c = 0; c < LANES; c++) begin
            color_val_ff[c] <= '0;
         end
      end else begin
         if (cmd.clear) begin
            length_ff <= '0;
         end else if (cmd.grow && ({1'b0, req_ff.point_index} >= length_ff)) begin
            length_ff <= {1'b0, req_ff.point_index} + LEN_W'(1);
         end
         if (cmd.record && is_color) begin
            color_idx_ff <= req_ff.point_index;
            color_open_ff <= 1'b1;
            for (int c = 0; c < LANES; c++) begin
               color_val_ff[c] <= req_rgb[c];
            end
         end
         if (cmd.record && is_opacity) begin
            op_idx_ff <= req_ff.point_index;
            op_val_ff <= req_ff.opacity_in;
            op_open_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         ent_vld_ff <= '0;
      end else if (cmd.fill_step && (is_color || in_len)) begin
         ent_vld_ff[addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_step) begin
         if (is_color) begin
            rgb_mem[addr_ff] <= {lane_val[2], lane_val[1], lane_val[0]};
            alpha_mem[addr_ff] <= '1;
         end else if (in_len) begin
            alpha_mem[addr_ff] <= lane_val[0];
            if (!ent_vld_ff[addr_ff]) begin
               rgb_mem[addr_ff] <= '0;
            end
         end
      end
      if (cmd.rd) begin
         rd_rgb_ff <= rgb_mem[req_ff.point_index];
         rd_alpha_ff <= alpha_mem[req_ff.point_index];
         rd_vld_ff <= ent_vld_ff[req_ff.point_index];
         rd_in_table_ff <= {1'b0, req_ff.point_index} < length_ff;
      end
   end

   always_comb begin
      rsp_data.red_out = rd_vld_ff ? rd_rgb_ff[CHANNEL_BITS-1:0] : '0;
      rsp_data.green_out = rd_vld_ff ? rd_rgb_ff[2*CHANNEL_BITS-1:CHANNEL_BITS] : '0;
      rsp_data.blue_out = rd_vld_ff ? rd_rgb_ff[3*CHANNEL_BITS-1:2*CHANNEL_BITS] : '0;
      rsp_data.alpha_out = rd_vld_ff ? rd_alpha_ff : '0;
      rsp_data.in_table = rd_in_table_ff;
   end

endmodule
`default_nettype wire

[hdl/plrtb_ctrl.sv]
`default_nettype none
module plrtb_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire plrtb_pkg::ctrl_status_type status,
   output plrtb_pkg::ctrl_cmd_type cmd,
   output logic busy,
   output logic rsp_valid
);
   import plrtb_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_DIV = 3'd2;
   localparam logic [2:0] ST_FILL = 3'd3;
   localparam logic [2:0] ST_RESP = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.cap = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            unique case (status.cmd)
               CMD_READ: begin
                  cmd.rd = 1'b1;
                  state_in = ST_RESP;
               end
               CMD_COLOR, CMD_OPACITY: begin
                  if (status.chain_start) begin
                     cmd.record = 1'b1;
                     cmd.clear = status.cmd == CMD_COLOR;
                  end else if (status.same_index) begin
                     cmd.record = 1'b1;
                  end else if (!status.descending) begin
                     cmd.div_start = 1'b1;
                     state_in = ST_DIV;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.fill_init = 1'b1;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               cmd.record = 1'b1;
               cmd.grow = status.cmd == CMD_COLOR;
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_RESP;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe held");
   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> rsp_valid) else $error("read without response");
   a_fill_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_init |-> $past(state_ff) == ST_DIV || $past(state_ff) == ST_DECIDE)
      else $error("fill started without division");
   a_no_step_while_div: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> status.div_done) else $error("fill before division done");

endmodule
`default_nettype wire

[hdl/piecewise_linear_rgba_table_builder_core.sv]
// Read request: the result strobe follows acceptance through the decide and
// response states, and busy covers both. Point request: busy only in the decide
// state when no entries are filled, otherwise also through the slope division
// and one table write per entry. Cleared by synchronous active-high reset; the
// table valid bits clear at once, so the table reads as zero right after reset.
`default_nettype none
module piecewise_linear_rgba_table_builder_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire plrtb_pkg::req_type req_data,
   output logic busy,
   output logic rsp_valid,
   output plrtb_pkg::rsp_type rsp_data
);
   import plrtb_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_status_type status;

   plrtb_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .status(status),
      .cmd(cmd),
      .busy(busy),
      .rsp_valid(rsp_valid)
   );

   plrtb_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .cmd(cmd),
      .status(status),
      .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

[dv/piecewise_linear_rgba_table_builder_core_tb.sv]
`default_nettype none
module piecewise_linear_rgba_table_builder_core_tb;
   import plrtb_pkg::*;

   logic clock;
   logic reset;
   logic start;
   req_type req_data;
   logic busy;
   logic rsp_valid;
   rsp_type rsp_data;

   piecewise_linear_rgba_table_builder_core u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   localparam logic [CHANNEL_BITS-1:0] FULL = '1;

   logic [CHANNEL_BITS-1:0] lut_rgba [TABLE_ENTRIES][4];
   int unsigned lut_length;
   int unsigned color_idx;
   logic [CHANNEL_BITS-1:0] color_val [3];
   bit color_open;
   int unsigned alpha_idx;
   logic [CHANNEL_BITS-1:0] alpha_val;
   bit alpha_open;

   req_type pending_requests[$];
   rsp_type expected_entries[$];
   int error_count = 0;
   int sender_idle_pct = 0;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [CHANNEL_BITS-1:0] interpolate(
      logic [CHANNEL_BITS-1:0] v0, logic [CHANNEL_BITS-1:0] v1,
      int unsigned k, int unsigned d);
      longint unsigned num;
      num = longint'(v0) * (d - k) + longint'(v1) * k + d / 2;
      return CHANNEL_BITS'(num / d);
   endfunction

   task automatic clear_lut();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         for (int c = 0; c < 4; c++) begin
            lut_rgba[i][c] = '0;
         end
      end
      lut_length = 0;
   endtask

   task automatic predict_request(req_type r);
      logic [CHANNEL_BITS-1:0] rgb [3];
      int unsigned idx;
      int unsigned d;
      rsp_type e;
      idx = r.point_index;
      rgb[0] = r.red_in;
      rgb[1] = r.green_in;
      rgb[2] = r.blue_in;
      case (r.cmd)
         CMD_COLOR: begin
            if (r.first_point || !color_open) begin
               clear_lut();
               color_open = 1;
            end else if (idx < color_idx) begin
               return;
            end else if (idx > color_idx) begin
               d = idx - color_idx;
               for (int unsigned i = color_idx; i <= idx; i++) begin
                  for (int c = 0; c < 3; c++) begin
                     lut_rgba[i][c] = interpolate(color_val[c], rgb[c], i - color_idx, d);
                  end
                  lut_rgba[i][3] = FULL;
               end
               if (idx + 1 > lut_length) lut_length = idx + 1;
            end
            color_idx = idx;
            color_val = rgb;
         end
         CMD_OPACITY: begin
            if (r.first_point || !alpha_open) begin
               alpha_open = 1;
            end else if (idx < alpha_idx) begin
               return;
            end else if (idx > alpha_idx) begin
               d = idx - alpha_idx;
               for (int unsigned i = alpha_idx; i <= idx && i < lut_length; i++) begin
                  lut_rgba[i][3] = interpolate(alpha_val, r.opacity_in, i - alpha_idx, d);
               end
            end
            alpha_idx = idx;
            alpha_val = r.opacity_in;
         end
         CMD_READ: begin
            e.red_out = lut_rgba[idx][0];
            e.green_out = lut_rgba[idx][1];
            e.blue_out = lut_rgba[idx][2];
            e.alpha_out = lut_rgba[idx][3];
            e.in_table = idx < lut_length;
            expected_entries.push_back(e);
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         start <= 1'b0;
      end else if (!start && pending_requests.size() > 0
                   && $urandom_range(99) >= sender_idle_pct) begin
         req_data <= pending_requests.pop_front();
         start <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) predict_request(req_data);
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_entries.size() == 0) begin
            report_mismatch("unexpected response", 0, 0);
         end else begin
            e = expected_entries.pop_front();
            if (rsp_data.red_out !== e.red_out)
               report_mismatch("red", rsp_data.red_out, e.red_out);
            if (rsp_data.green_out !== e.green_out)
               report_mismatch("green", rsp_data.green_out, e.green_out);
            if (rsp_data.blue_out !== e.blue_out)
               report_mismatch("blue", rsp_data.blue_out, e.blue_out);
            if (rsp_data.alpha_out !== e.alpha_out)
               report_mismatch("alpha", rsp_data.alpha_out, e.alpha_out);
            if (rsp_data.in_table !== e.in_table)
               report_mismatch("in_table", rsp_data.in_table, e.in_table);
         end
      end
   end

   function automatic req_type make_request(logic [1:0] cmd, bit first, int unsigned idx,
                                            int unsigned value);
      req_type r;
      r.cmd = cmd;
      r.first_point = first;
      r.point_index = IDX_W'(idx);
      r.red_in = CHANNEL_BITS'($urandom);
      r.green_in = CHANNEL_BITS'($urandom);
      r.blue_in = CHANNEL_BITS'($urandom);
      r.opacity_in = CHANNEL_BITS'(value);
      if (cmd == CMD_COLOR) r.red_in = CHANNEL_BITS'(value);
      return r;
   endfunction

   task automatic add_reads(int n);
      for (int i = 0; i < n; i++) begin
         pending_requests.push_back(make_request(CMD_READ, 1'($urandom_range(1)),
                                                 $urandom_range(255), $urandom));
      end
   endtask

   task automatic add_chain_set();
      int unsigned idx;
      int unsigned span;
      pending_requests.push_back(make_request(CMD_COLOR, 1, $urandom_range(20), $urandom));
      idx = 0;
      repeat ($urandom_range(2, 5)) begin
         span = ($urandom_range(9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 12);
         idx = (pending_requests[$].point_index + span > 255) ? 255
               : pending_requests[$].point_index + span;
         pending_requests.push_back(make_request(CMD_COLOR, $urandom_range(15) == 0,
                                                 idx, $urandom));
      end
      pending_requests.push_back(make_request(CMD_OPACITY, 1, $urandom_range(10), $urandom));
      repeat ($urandom_range(1, 4)) begin
         span = $urandom_range(0, 15);
         idx = (pending_requests[$].point_index + span > 255) ? 255
               : pending_requests[$].point_index + span;
         pending_requests.push_back(make_request(CMD_OPACITY, 0, idx, $urandom));
      end
      if ($urandom_range(3) == 0) begin
         pending_requests.push_back(make_request(2'($urandom_range(1)), 0,
                                                 $urandom_range(255), $urandom));
         pending_requests.push_back(make_request(CMD_NONE, 1'($urandom_range(1)),
                                                 $urandom_range(255), $urandom));
      end
      add_reads($urandom_range(2, 6));
   endtask

   task automatic wait_drained();
      while (pending_requests.size() > 0 || start || busy || expected_entries.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      clear_lut();
      color_idx = 0;
      color_val = '{default: '0};
      color_open = 0;
      alpha_idx = 0;
      alpha_val = '0;
      alpha_open = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      pending_requests.push_back(make_request(CMD_READ, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_COLOR, 0, 3, 16'hffff));
      pending_requests.push_back(make_request(CMD_COLOR, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_COLOR, 1, 0, 16'hffff));
      pending_requests.push_back(make_request(CMD_COLOR, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_COLOR, 0, 7, 16'hffff));
      pending_requests.push_back(make_request(CMD_COLOR, 0, 5, 16'h1234));
      pending_requests.push_back(make_request(CMD_COLOR, 0, 255, 0));
      pending_requests.push_back(make_request(CMD_OPACITY, 0, 2, 16'hffff));
      pending_requests.push_back(make_request(CMD_OPACITY, 0, 2, 0));
      pending_requests.push_back(make_request(CMD_OPACITY, 0, 9, 16'hffff));
      pending_requests.push_back(make_request(CMD_OPACITY, 0, 4, 7));
      pending_requests.push_back(make_request(CMD_NONE, 1, 255, 16'hffff));
      pending_requests.push_back(make_request(CMD_READ, 1, 255, 0));
      pending_requests.push_back(make_request(CMD_READ, 0, 4, 0));
      pending_requests.push_back(make_request(CMD_READ, 0, 8, 0));
      pending_requests.push_back(make_request(CMD_COLOR, 1, 10, 0));
      pending_requests.push_back(make_request(CMD_COLOR, 0, 12, 1));
      pending_requests.push_back(make_request(CMD_OPACITY, 0, 200, 3));
      pending_requests.push_back(make_request(CMD_READ, 0, 11, 0));
      pending_requests.push_back(make_request(CMD_READ, 0, 13, 0));
      pending_requests.push_back(make_request(CMD_READ, 0, 0, 0));
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: sender_idle_pct = 0;
            1: sender_idle_pct = 81;
            2: sender_idle_pct = 0;
            default: sender_idle_pct = 32;
         endcase
         while (pending_requests.size() < 105) add_chain_set();
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_entries.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire
